### hdl/assert_macros.svh
// Assertion macros shared by the distance block's modules.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Single concurrent property, checked on each rising clock edge outside reset.
`define VPND_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define VPND_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/vpnd_pkg.sv
// Shared types and constants of the p-norm distance block.
// No dependencies.
package vpnd_pkg;

  localparam int ELEM_WIDTH = 16;
  localparam int ACC_WIDTH  = 48;
  localparam int AD_WIDTH   = ELEM_WIDTH + 1;
  localparam int CFG_WIDTH  = 16;
  localparam int DIST_WIDTH = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    MODE_MANHATTAN = 2'd0,
    MODE_EUCLIDEAN = 2'd1,
    MODE_CHEBYSHEV = 2'd2,
    MODE_GENERIC   = 2'd3
  } norm_mode_e;

  typedef enum logic [1:0] {
    CFG_NORM_MODE = 2'd0,
    CFG_P_EXP     = 2'd1,
    CFG_INV_P     = 2'd2,
    CFG_EPSILON   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [AD_WIDTH-1:0] ad;
    logic                last;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

endpackage

### hdl/vpnd_fifo.sv
// Short request queue between the front and back parts.
// Depends on vpnd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vpnd_fifo
  import vpnd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  input  logic  pop_i,
  output item_t data_o,
  output logic  full_o,
  output logic  empty_o
);

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + FIFO_AW'(1);
    end
    if (pop_i) begin
      rd_d = rd_q + FIFO_AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (FIFO_AW+1)'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `VPND_ASSERT(a_no_push_full, clk_i, rst_ni, full_o |-> !push_i, "push into full queue")
  `VPND_ASSERT(a_no_pop_empty, clk_i, rst_ni, empty_o |-> !pop_i, "pop from empty queue")

endmodule

### hdl/vpnd_isqrt.sv
// Iterative 64-bit integer square root, one result bit per cycle.
// Depends on vpnd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vpnd_isqrt
  import vpnd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sqrt_req_t req_i,
  output sqrt_rsp_t rsp_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] n_q, n_d, res_q, res_d, bit_q, bit_d, trial;

  assign trial = res_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    n_d    = n_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      n_d    = req_i.radicand;
      res_d  = '0;
      bit_d  = 64'd1 << 62;
    end else if (busy_q) begin
      if (n_q >= trial) begin
        n_d   = n_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.root = res_q[31:0];

  `VPND_ASSERT(a_start_idle, clk_i, rst_ni, req_i.start |-> !busy_q, "root started while busy")
  `VPND_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, req_i.start, busy_q && !done_q,
                    "root start not taken")

endmodule

### hdl/vpnd_front.sv
// Front part: takes element pairs, forms the absolute difference, queues it.
// Depends on vpnd_pkg.
module vpnd_front
  import vpnd_pkg::*;
(
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [ELEM_WIDTH-1:0] first_elem_i,
  input  logic signed [ELEM_WIDTH-1:0] second_elem_i,
  input  logic                         row_end_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output item_t                        q_data_o
);

  logic signed [AD_WIDTH-1:0] diff;

  assign diff       = AD_WIDTH'(first_elem_i) - AD_WIDTH'(second_elem_i);
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_data_o.last = row_end_i;
    if (diff[AD_WIDTH-1]) begin
      q_data_o.ad = AD_WIDTH'(0) - diff;
    end else begin
      q_data_o.ad = diff;
    end
  end

endmodule

### hdl/vpnd_back.sv
// Back part: accumulates terms, runs log2/exp2 and roots, holds the result.
// Depends on vpnd_pkg; uses vpnd_isqrt through its request and response structs.
module vpnd_back
  import vpnd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  item_t                 item_i,
  input  logic                  item_empty_i,
  output logic                  item_pop_o,
  input  norm_mode_e            mode_i,
  input  logic [CFG_WIDTH-1:0]  p_exp_i,
  input  logic [CFG_WIDTH-1:0]  inv_p_i,
  input  logic [CFG_WIDTH-1:0]  eps_i,
  output sqrt_req_t             sqrt_req_o,
  input  sqrt_rsp_t             sqrt_rsp_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DIST_WIDTH-1:0] distance_o,
  output logic                  overflowed_o
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_ACC   = 12'b0000_0000_0010,
    S_NORM  = 12'b0000_0000_0100,
    S_SQM   = 12'b0000_0000_1000,
    S_SQC   = 12'b0000_0001_0000,
    S_EMUL  = 12'b0000_0010_0000,
    S_EXPS  = 12'b0000_0100_0000,
    S_EXPW  = 12'b0000_1000_0000,
    S_SHIFT = 12'b0001_0000_0000,
    S_FIN   = 12'b0010_0000_0000,
    S_RTW   = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_e;

  localparam logic [63:0] OUT_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] ACC_LIM = {{(64-ACC_WIDTH){1'b0}}, {ACC_WIDTH{1'b1}}};

  state_e                state_q, state_d;
  logic [ACC_WIDTH-1:0]  sum_q, sum_d;
  logic                  ssat_q, ssat_d, osat_q, osat_d;
  logic [AD_WIDTH-1:0]   ad_q, ad_d;
  logic                  last_q, last_d, final_q, final_d;
  logic [63:0]           x_q, x_d;
  logic [5:0]            m_q, m_d;
  logic [30:0]           y_q, y_d;
  logic [61:0]           prod_q, prod_d;
  logic [15:0]           fb_q, fb_d;
  logic [3:0]            i_q, i_d, j_q, j_d;
  logic [28:0]           e_q, e_d;
  logic [31:0]           r_q, r_d;
  logic [DIST_WIDTH-1:0] res_q, res_d, dout_q, dout_d;
  logic                  oflow_q, oflow_d, ovalid_q, ovalid_d;

  logic [2*AD_WIDTH-1:0] sq;
  logic [ACC_WIDTH:0]    v_sum;
  logic [7:0]            m_adj;
  logic signed [23:0]    lg;
  logic signed [16:0]    pmul;
  logic signed [40:0]    eprod;
  logic [13:0]           sh, nsh;
  logic [15:0]           fpart;
  logic [31:0]           yy;
  logic [32:0]           rr;
  logic [63:0]           lim, exp_val;
  logic                  exp_sat;
  logic [31:0]           s8;
  logic [32:0]           tot;

  assign sq    = ad_q * ad_q;
  assign v_sum = {1'b0, sum_q} + (ACC_WIDTH+1)'(eps_i);
  assign m_adj = {2'b00, m_q} - (final_q ? 8'd16 : 8'd8);
  assign lg    = {m_adj, fb_q};
  assign pmul  = {1'b0, (final_q ? inv_p_i : p_exp_i)};
  assign eprod = lg * pmul;
  assign sh    = {e_q[28], e_q[28:16]} - 14'd14;
  assign nsh   = 14'd0 - sh;
  assign fpart = e_q[15:0];
  assign yy    = prod_q[61:30];
  assign rr    = fpart[j_q] ? {r_q, 1'b0} : {1'b0, r_q};
  assign lim   = final_q ? OUT_MAX : ACC_LIM;
  assign s8    = {sum_q[23:0], 8'h00};
  assign tot   = {1'b0, s8} + 33'(eps_i);

  always_comb begin
    exp_sat = 1'b0;
    exp_val = '0;
    if (!sh[13]) begin
      if ((sh[12:6] != '0) || (sh[5:0] > 6'd32)) begin
        exp_sat = 1'b1;
        exp_val = lim;
      end else begin
        exp_val = {32'h0, r_q} << sh[5:0];
        if (exp_val > lim) begin
          exp_sat = 1'b1;
          exp_val = lim;
        end
      end
    end else if (nsh[13:6] == '0) begin
      exp_val = {32'h0, r_q} >> nsh[5:0];
    end
  end

  always_comb begin
    logic [ACC_WIDTH:0] sum_ext;
    sum_ext    = '0;
    state_d    = state_q;
    sum_d      = sum_q;
    ssat_d     = ssat_q;
    osat_d     = osat_q;
    ad_d       = ad_q;
    last_d     = last_q;
    final_d    = final_q;
    x_d        = x_q;
    m_d        = m_q;
    y_d        = y_q;
    prod_d     = prod_q;
    fb_d       = fb_q;
    i_d        = i_q;
    j_d        = j_q;
    e_d        = e_q;
    r_d        = r_q;
    res_d      = res_q;
    dout_d     = dout_q;
    oflow_d    = oflow_q;
    ovalid_d   = ovalid_q;
    item_pop_o = 1'b0;
    sqrt_req_o = '0;
    if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (!item_empty_i) begin
          item_pop_o = 1'b1;
          ad_d       = item_i.ad;
          last_d     = item_i.last;
          state_d    = S_ACC;
        end
      end
      S_ACC: begin
        state_d = S_FIN;
        unique case (mode_i)
          MODE_MANHATTAN: begin
            sum_ext = {1'b0, sum_q} + (ACC_WIDTH+1)'(ad_q);
          end
          MODE_EUCLIDEAN: begin
            sum_ext = {1'b0, sum_q} + (ACC_WIDTH+1)'(sq);
          end
          MODE_CHEBYSHEV: begin
            sum_ext = {1'b0, sum_q};
            if (ACC_WIDTH'(ad_q) > sum_q) begin
              sum_ext = (ACC_WIDTH+1)'(ad_q);
            end
          end
          MODE_GENERIC: begin
            sum_ext = {1'b0, sum_q};
            if (ad_q != '0) begin
              x_d     = 64'(ad_q);
              m_d     = 6'd63;
              final_d = 1'b0;
              state_d = S_NORM;
            end
          end
        endcase
        if (sum_ext[ACC_WIDTH]) begin
          sum_d  = {ACC_WIDTH{1'b1}};
          ssat_d = 1'b1;
        end else begin
          sum_d = sum_ext[ACC_WIDTH-1:0];
        end
      end
      S_NORM: begin
        if (x_q[63]) begin
          y_d     = x_q[63:33];
          fb_d    = '0;
          i_d     = 4'd15;
          state_d = S_SQM;
        end else begin
          x_d = x_q << 1;
          m_d = m_q - 6'd1;
        end
      end
      S_SQM: begin
        prod_d  = y_q * y_q;
        state_d = S_SQC;
      end
      S_SQC: begin
        if (yy[31]) begin
          y_d       = yy[31:1];
          fb_d[i_q] = 1'b1;
        end else begin
          y_d = yy[30:0];
        end
        if (i_q == 4'd0) begin
          state_d = S_EMUL;
        end else begin
          i_d     = i_q - 4'd1;
          state_d = S_SQM;
        end
      end
      S_EMUL: begin
        e_d     = eprod[40:12];
        r_d     = 32'h4000_0000;
        j_d     = '0;
        state_d = S_EXPS;
      end
      S_EXPS: begin
        sqrt_req_o.start    = 1'b1;
        sqrt_req_o.radicand = {1'b0, rr, 30'h0};
        state_d             = S_EXPW;
      end
      S_EXPW: begin
        if (sqrt_rsp_i.done) begin
          r_d = sqrt_rsp_i.root;
          if (j_q == 4'd15) begin
            state_d = S_SHIFT;
          end else begin
            j_d     = j_q + 4'd1;
            state_d = S_EXPS;
          end
        end
      end
      S_SHIFT: begin
        if (final_q) begin
          res_d   = exp_val[DIST_WIDTH-1:0];
          osat_d  = osat_q | exp_sat;
          state_d = S_OUT;
        end else begin
          sum_ext = {1'b0, sum_q} + {1'b0, exp_val[ACC_WIDTH-1:0]};
          if (sum_ext[ACC_WIDTH]) begin
            sum_d  = {ACC_WIDTH{1'b1}};
            ssat_d = 1'b1;
          end else begin
            sum_d  = sum_ext[ACC_WIDTH-1:0];
            ssat_d = ssat_q | exp_sat;
          end
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else begin
          osat_d  = 1'b0;
          state_d = S_OUT;
          unique case (mode_i)
            MODE_MANHATTAN: begin
              if (sum_q[ACC_WIDTH-1:24] != '0) begin
                osat_d = 1'b1;
                res_d  = '1;
              end else if (tot[32]) begin
                osat_d = 1'b1;
                res_d  = '1;
              end else begin
                res_d = tot[31:0];
              end
            end
            MODE_CHEBYSHEV: begin
              if (sum_q[ACC_WIDTH-1:24] != '0) begin
                osat_d = 1'b1;
                res_d  = '1;
              end else begin
                res_d = s8;
              end
            end
            MODE_EUCLIDEAN: begin
              if (v_sum[ACC_WIDTH]) begin
                osat_d = 1'b1;
                res_d  = '1;
              end else begin
                sqrt_req_o.start    = 1'b1;
                sqrt_req_o.radicand = {v_sum[ACC_WIDTH-1:0], 16'h0000};
                state_d             = S_RTW;
              end
            end
            MODE_GENERIC: begin
              if (v_sum == '0) begin
                res_d = '0;
              end else begin
                x_d     = 64'(v_sum);
                m_d     = 6'd63;
                final_d = 1'b1;
                state_d = S_NORM;
              end
            end
          endcase
        end
      end
      S_RTW: begin
        if (sqrt_rsp_i.done) begin
          res_d   = sqrt_rsp_i.root;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          dout_d   = res_q;
          oflow_d  = ssat_q | osat_q;
          sum_d    = '0;
          ssat_d   = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sum_q    <= '0;
      ssat_q   <= 1'b0;
      osat_q   <= 1'b0;
      ovalid_q <= 1'b0;
      last_q   <= 1'b0;
      final_q  <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
    end else begin
      state_q  <= state_d;
      sum_q    <= sum_d;
      ssat_q   <= ssat_d;
      osat_q   <= osat_d;
      ovalid_q <= ovalid_d;
      last_q   <= last_d;
      final_q  <= final_d;
      i_q      <= i_d;
      j_q      <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ad_q    <= ad_d;
    x_q     <= x_d;
    m_q     <= m_d;
    y_q     <= y_d;
    prod_q  <= prod_d;
    fb_q    <= fb_d;
    e_q     <= e_d;
    r_q     <= r_d;
    res_q   <= res_d;
    dout_q  <= dout_d;
    oflow_q <= oflow_d;
  end

  assign out_valid_o  = ovalid_q;
  assign distance_o   = dout_q;
  assign overflowed_o = oflow_q;

endmodule

### hdl/vector_p_norm_distance_top.sv
// Top level of the p-norm row distance block: configuration registers and wiring.
// Depends on vpnd_pkg, vpnd_front, vpnd_fifo, vpnd_back and vpnd_isqrt.
//
// Element pairs enter at up to one per cycle, while the queue is not full, into a
// four-entry queue. In manhattan, euclidean and chebyshev modes the back end pops
// each pair, folds it into the row sum and checks for a row end. In generic p mode
// a nonzero pair is normalised, goes through the log2 squarings and then 16 exp2
// steps on the shared bit-serial square-root unit, which sets the pace. A row end
// adds a square root in euclidean mode and a further log2/exp2 pass in generic
// mode. A finished distance waits in an output register while the next row's
// pairs are taken.
module vector_p_norm_distance_top
  import vpnd_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [ELEM_WIDTH-1:0] first_elem_i,
  input  logic signed [ELEM_WIDTH-1:0] second_elem_i,
  input  logic                         row_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [DIST_WIDTH-1:0]        distance_o,
  output logic                         overflowed_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]         cfg_data_i
);

  norm_mode_e           mode_q;
  logic [CFG_WIDTH-1:0] p_exp_q, inv_p_q, eps_q;
  logic                 q_push, q_pop, q_full, q_empty;
  item_t                q_in, q_out;
  sqrt_req_t            sqrt_req;
  sqrt_rsp_t            sqrt_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_EUCLIDEAN;
      p_exp_q <= 16'd8192;
      inv_p_q <= 16'd2048;
      eps_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NORM_MODE: mode_q  <= norm_mode_e'(cfg_data_i[1:0]);
        CFG_P_EXP:     p_exp_q <= cfg_data_i;
        CFG_INV_P:     inv_p_q <= cfg_data_i;
        CFG_EPSILON:   eps_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  vpnd_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .first_elem_i  (first_elem_i),
    .second_elem_i (second_elem_i),
    .row_end_i     (row_end_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_in)
  );

  vpnd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  vpnd_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  vpnd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (q_out),
    .item_empty_i (q_empty),
    .item_pop_o   (q_pop),
    .mode_i       (mode_q),
    .p_exp_i      (p_exp_q),
    .inv_p_i      (inv_p_q),
    .eps_i        (eps_q),
    .sqrt_req_o   (sqrt_req),
    .sqrt_rsp_i   (sqrt_rsp),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .distance_o   (distance_o),
    .overflowed_o (overflowed_o)
  );

endmodule

### sim/vector_p_norm_distance_top_tb.sv
// Testbench for the p-norm row distance block: directed and random rows in all four modes.
// Depends on vpnd_pkg and vector_p_norm_distance_top; each distance is checked against
// an in-bench fixed-point predictor.
`timescale 1ns / 1ps

module vector_p_norm_distance_top_tb;
  import vpnd_pkg::*;

  localparam int  SETTLE_CYCLES = 3000;
  localparam longint CYCLE_LIMIT = 10000000;
  localparam longint unsigned ACC_MAX = (64'd1 << ACC_WIDTH) - 1;
  localparam longint unsigned OUT_MAX = 64'hFFFF_FFFF;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef struct {
    logic [DIST_WIDTH-1:0] distance;
    logic                  overflowed;
  } row_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic signed [ELEM_WIDTH-1:0] first_elem_i;
  logic signed [ELEM_WIDTH-1:0] second_elem_i;
  logic                         row_end_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [DIST_WIDTH-1:0]        distance_o;
  logic                         overflowed_o;
  logic                         cfg_we_i;
  logic [1:0]                   cfg_idx_i;
  logic [CFG_WIDTH-1:0]         cfg_data_i;

  norm_mode_e        mode_q;
  logic [15:0]       p_q, inv_p_q, eps_q;
  longint unsigned   row_sum;
  bit                row_sum_sat;
  row_result_t       pending_distances[$];
  int                fail_count;
  int                pairs_sent;
  longint            cycle_count;

  vector_p_norm_distance_top uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                              longint unsigned lim, inout bit sat);
    if (a > lim || b > lim - a) begin
      sat = 1'b1;
      return lim;
    end
    return a + b;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint log2_fix(longint unsigned x, int frac);
    int m;
    longint unsigned y;
    longint fbits;
    m = 63;
    fbits = 0;
    while (m > 0 && x[m] == 1'b0) m--;
    y = (m >= 30) ? (x >> (m - 30)) : (x << (30 - m));
    for (int i = 15; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= 2 * ONE_Q30) begin
        y >>= 1;
        fbits |= longint'(1) << i;
      end
    end
    return longint'(m - frac) * 65536 + fbits;
  endfunction

  function automatic longint unsigned exp2_fix(longint e, longint unsigned lim, inout bit sat);
    longint k, sh;
    longint unsigned f, r, v;
    k = e >>> 16;
    f = longint'(e - k * 65536);
    r = ONE_Q30;
    for (int i = 0; i < 16; i++) begin
      if (f[i]) r <<= 1;
      r = isqrt(r << 30);
    end
    sh = k + 16 - 30;
    if (sh >= 0) begin
      if (sh > 32) begin
        sat = 1'b1;
        return lim;
      end
      v = r << sh;
      if (v > lim) begin
        sat = 1'b1;
        return lim;
      end
      return v;
    end
    if (-sh >= 64) return 0;
    return r >> (-sh);
  endfunction

  // advance the row accumulator by one pair and queue a distance at row end
  task automatic predict_distance(logic signed [15:0] a, logic signed [15:0] b, logic last);
    longint d, e;
    longint unsigned ad, v, t;
    bit osat;
    row_result_t res;
    d = longint'(a) - longint'(b);
    ad = (d < 0) ? -d : d;
    osat = 1'b0;
    case (mode_q)
      MODE_MANHATTAN: row_sum = sat_add(row_sum, ad, ACC_MAX, row_sum_sat);
      MODE_EUCLIDEAN: row_sum = sat_add(row_sum, ad * ad, ACC_MAX, row_sum_sat);
      MODE_CHEBYSHEV: if (ad > row_sum) row_sum = ad;
      default: begin
        if (ad != 0) begin
          e = (log2_fix(ad, 8) * longint'({1'b0, p_q})) >>> 12;
          t = exp2_fix(e, ACC_MAX, row_sum_sat);
          row_sum = sat_add(row_sum, t, ACC_MAX, row_sum_sat);
        end
      end
    endcase
    if (!last) return;
    case (mode_q)
      MODE_MANHATTAN: begin
        if (row_sum > (OUT_MAX >> 8)) begin
          osat = 1'b1;
          v = OUT_MAX;
        end else begin
          v = sat_add(row_sum << 8, eps_q, OUT_MAX, osat);
        end
      end
      MODE_EUCLIDEAN: begin
        v = row_sum + eps_q;
        if (v >= (64'd1 << 48)) begin
          osat = 1'b1;
          v = OUT_MAX;
        end else begin
          v = isqrt(v << 16);
        end
      end
      MODE_CHEBYSHEV: begin
        if (row_sum > (OUT_MAX >> 8)) begin
          osat = 1'b1;
          v = OUT_MAX;
        end else begin
          v = row_sum << 8;
        end
      end
      default: begin
        v = row_sum + eps_q;
        if (v != 0) begin
          e = (log2_fix(v, 16) * longint'({1'b0, inv_p_q})) >>> 12;
          v = exp2_fix(e, OUT_MAX, osat);
        end
      end
    endcase
    res.distance = v[31:0];
    res.overflowed = row_sum_sat | osat;
    pending_distances.push_back(res);
    row_sum = 0;
    row_sum_sat = 1'b0;
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] rand_elem();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    if (r < 6) return 16'($urandom_range(0, 65535));
    return 16'($signed($urandom_range(0, 1023)) - 512);
  endfunction

  task automatic send_pair(logic [15:0] a, logic [15:0] b, logic last);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    first_elem_i  <= a;
    second_elem_i <= b;
    row_end_i     <= last;
    do @(posedge clk_i); while (in_stall_o);
    predict_distance(a, b, last);
    pairs_sent++;
  endtask

  task automatic send_row(int len);
    for (int i = 0; i < len; i++) send_pair(rand_elem(), rand_elem(), i == len - 1);
  endtask

  // hold until every distance has arrived and the back end has gone quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_NORM_MODE: mode_q = norm_mode_e'(data[1:0]);
      CFG_P_EXP:     p_q = data;
      CFG_INV_P:     inv_p_q = data;
      default:       eps_q = data;
    endcase
  endtask

  task automatic set_config(norm_mode_e m, logic [15:0] p, logic [15:0] ip, logic [15:0] eps);
    drain();
    write_reg(CFG_NORM_MODE, 16'(m));
    write_reg(CFG_P_EXP, p);
    write_reg(CFG_INV_P, ip);
    write_reg(CFG_EPSILON, eps);
  endtask

  task automatic test_simple_modes();
    set_config(MODE_MANHATTAN, 16'd4096, 16'd4096, 16'hFFFF);
    send_pair(16'h7FFF, 16'h8000, 1'b0);
    send_pair(16'h8000, 16'h7FFF, 1'b1);
    send_pair(16'h0100, 16'h0100, 1'b1);
    set_config(MODE_EUCLIDEAN, 16'd4096, 16'd4096, 16'd0);
    send_pair(16'h7FFF, 16'h8000, 1'b0);
    send_pair(16'h0300, 16'h0000, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    set_config(MODE_CHEBYSHEV, 16'd4096, 16'd4096, 16'h1234);
    send_pair(16'h0010, 16'hFFF0, 1'b0);
    send_pair(16'h8000, 16'h7FFF, 1'b0);
    send_pair(16'h0001, 16'h0000, 1'b1);
  endtask

  task automatic test_generic_mode();
    set_config(MODE_GENERIC, 16'd12288, 16'd1365, 16'd0);
    send_pair(16'h0200, 16'h0100, 1'b0);
    send_pair(16'h0100, 16'h0100, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    set_config(MODE_GENERIC, 16'hFFFF, 16'd1, 16'hFFFF);
    send_pair(16'h7FFF, 16'h8000, 1'b1);
    set_config(MODE_GENERIC, 16'd0, 16'd0, 16'd1);
    send_pair(16'h0050, 16'h0020, 1'b0);
    send_pair(16'h1000, 16'h0000, 1'b1);
    set_config(MODE_GENERIC, 16'd1, 16'hFFFF, 16'hFFFF);
    send_pair(16'h7FFF, 16'h8000, 1'b0);
    send_pair(16'h4000, 16'hC000, 1'b1);
  endtask

  task automatic test_mode_switch_mid_row();
    set_config(MODE_MANHATTAN, 16'd8192, 16'd2048, 16'd0);
    send_pair(16'h0300, 16'h0100, 1'b0);
    drain();
    write_reg(CFG_NORM_MODE, 16'(MODE_EUCLIDEAN));
    send_pair(16'h0100, 16'h0000, 1'b1);
  endtask

  task automatic test_sender_pause();
    set_config(MODE_EUCLIDEAN, 16'd8192, 16'd2048, 16'd77);
    send_row(3);
    send_row(2);
    in_valid_i <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk_i);
    send_row(4);
  endtask

  task automatic test_random_rows();
    norm_mode_e m;
    logic [15:0] p, ip, eps;
    int budget, len;
    while (pairs_sent < 1000) begin
      m = norm_mode_e'($urandom_range(0, 3));
      if (m == MODE_GENERIC && $urandom_range(0, 2) != 0) m = MODE_MANHATTAN;
      case ($urandom_range(0, 3))
        0: p = 16'hFFFF;
        1: p = 16'($urandom_range(1, 65535));
        default: p = 16'($urandom_range(2048, 16384));
      endcase
      case ($urandom_range(0, 3))
        0: ip = 16'hFFFF;
        1: ip = 16'($urandom_range(1, 65535));
        default: ip = 16'($urandom_range(256, 4096));
      endcase
      eps = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      set_config(m, p, ip, eps);
      budget = (m == MODE_GENERIC) ? 25 : 80;
      while (budget > 0) begin
        if (m == MODE_MANHATTAN && $urandom_range(0, 7) == 0) begin
          // long row of large differences to push the output past 32 bits
          for (int i = 0; i < 300; i++) send_pair(16'h7FFF, 16'h8000, i == 299);
          budget -= 300;
        end else begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
          send_row(len);
          budget -= len;
        end
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    first_elem_i  = '0;
    second_elem_i = '0;
    row_end_i     = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_NORM_MODE;
    cfg_data_i    = '0;
    mode_q        = MODE_EUCLIDEAN;
    p_q           = 16'd8192;
    inv_p_q       = 16'd2048;
    eps_q         = 16'd0;
    row_sum       = 0;
    row_sum_sat   = 1'b0;
    fail_count    = 0;
    pairs_sent    = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_simple_modes();
    test_generic_mode();
    test_mode_switch_mid_row();
    test_sender_pause();
    test_random_rows();
    in_valid_i <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int len;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(50, 200)) @(posedge clk_i);
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        out_stall_i <= 1'b1;
        repeat (len) @(posedge clk_i);
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    row_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_distances.size() == 0) begin
        $error("distance with no request waiting: distance %h", distance_o);
        fail_count++;
      end else begin
        exp_res = pending_distances.pop_front();
        if (distance_o !== exp_res.distance) begin
          $error("distance: expected %h, actual %h", exp_res.distance, distance_o);
          fail_count++;
        end
        if (overflowed_o !== exp_res.overflowed) begin
          $error("overflowed: expected %b, actual %b", exp_res.overflowed, overflowed_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule

### filelist.f
+incdir+hdl
hdl/vpnd_pkg.sv
hdl/vpnd_fifo.sv
hdl/vpnd_isqrt.sv
hdl/vpnd_front.sv
hdl/vpnd_back.sv
hdl/vector_p_norm_distance_top.sv
sim/vector_p_norm_distance_top_tb.sv
